FILE: rtl/ffre_pkg.sv
// ----------------------------------------------------------------------------
// ffre_pkg
// Shared types, register codes and defaults for the frame flip/rotate engine.
// ----------------------------------------------------------------------------
package ffre_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_TRANSFORM_MODE = 2'd2;

  typedef struct packed {
    logic [7:0] pixel_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       out_valid;
    logic       end_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic [6:0] frame_width;
    logic [6:0] frame_height;
    logic       transform_mode;
    logic       restart;
  } cfg_t;

  typedef struct packed {
    logic seen;
    logic eof;
  } rd_meta_t;

endpackage

FILE: rtl/ffre_stream_if.sv
// ----------------------------------------------------------------------------
// ffre_stream_if
// Valid/ready stream channel; a transfer occurs when valid and ready are high.
// ----------------------------------------------------------------------------
interface ffre_stream_if #(
  parameter type payload_t = logic [7:0]
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/frame_flip_rotate_engine_top.sv
// ----------------------------------------------------------------------------
// frame_flip_rotate_engine_top
// Ping-pong frame store: writes the incoming frame, emits the previous one
// mirrored or rotated clockwise by 90 degrees.
// ----------------------------------------------------------------------------
// Path: a result passes the store read register, then the result queue, before
// it is offered. Throughput: one pixel per cycle while the result queue has room
// and the store is not clearing; one store write and one store read per pixel.
// Reset: counters, bank and first-frame flag clear at once; the store is then
// zeroed one entry per cycle, during which no pixel is taken. Register writes
// are taken at any time.
module frame_flip_rotate_engine_top import ffre_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  ffre_stream_if.sink           in_chan,
  ffre_stream_if.source         out_chan
);

  localparam int AW = $clog2(2 * MAX_WIDTH * MAX_HEIGHT);

  cfg_t          cfg;
  rd_meta_t      meta;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    rd_data;
  logic          mem_busy;
  logic          can_take;
  logic          step;

  assign in_chan.ready = can_take && !mem_busy;
  assign step          = in_chan.valid && in_chan.ready;

  ffre_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ffre_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (step),
    .rd_addr_o (rd_addr),
    .wr_addr_o (wr_addr),
    .meta_o    (meta)
  );

  ffre_frame_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_frame_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (step),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_chan.data.pixel_in),
    .rd_en_i   (step),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .busy_o    (mem_busy)
  );

  ffre_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (step),
    .meta_i     (meta),
    .rd_data_i  (rd_data),
    .can_take_o (can_take),
    .out_chan   (out_chan)
  );

  // read and write always land in opposite banks
  a_bank_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> rd_addr != wr_addr)
    else $error("read and write address collide");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mem_busy |=> !mem_busy)
    else $error("store clear restarted");

  a_first_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid && !out_chan.data.out_valid |->
      out_chan.data.pixel_out == 8'd0 && !out_chan.data.end_of_frame)
    else $error("first-frame result not zeroed");

  a_eof_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> !meta.eof || meta.seen)
    else $error("end of frame without stored frame");

endmodule

FILE: rtl/ffre_cfg.sv
// ----------------------------------------------------------------------------
// ffre_cfg
// APB register file: frame width, frame height and transform mode.
// ----------------------------------------------------------------------------
module ffre_cfg import ffre_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [6:0] width_q, width_d;
  logic [6:0] height_q, height_d;
  logic       mode_q, mode_d;
  logic       wr_stb;
  logic       hit;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_stb = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    hit      = 1'b0;
    unique case (idx)
      REG_FRAME_WIDTH: begin
        width_d = pwdata[6:0];
        hit     = 1'b1;
      end
      REG_FRAME_HEIGHT: begin
        height_d = pwdata[6:0];
        hit      = 1'b1;
      end
      REG_TRANSFORM_MODE: begin
        mode_d = pwdata[0];
        hit    = 1'b1;
      end
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd64;
      height_q <= 7'd64;
      mode_q   <= 1'b0;
    end else if (wr_stb) begin
      width_q  <= width_d;
      height_q <= height_d;
      mode_q   <= mode_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:    prdata = {25'd0, width_q};
      REG_FRAME_HEIGHT:   prdata = {25'd0, height_q};
      REG_TRANSFORM_MODE: prdata = {31'd0, mode_q};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = '{frame_width:    width_q,
                   frame_height:   height_q,
                   transform_mode: mode_q,
                   restart:        wr_stb && hit};

endmodule

FILE: rtl/ffre_addr_gen.sv
// ----------------------------------------------------------------------------
// ffre_addr_gen
// Raster write counters and transformed read counters; forms store addresses.
// ----------------------------------------------------------------------------
module ffre_addr_gen import ffre_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int BANK      = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW        = $clog2(2 * BANK)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          step_i,
  output logic [AW-1:0] rd_addr_o,
  output logic [AW-1:0] wr_addr_o,
  output rd_meta_t      meta_o
);

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EW      = DW + 2;

  logic [DW-1:0] wr_row_q, wr_col_q, rd_row_q, rd_col_q;
  logic          bank_q, seen_q;
  logic [EW-1:0] w, h, out_w, out_h;
  logic [DW-1:0] src_row, src_col;
  logic          last_read;

  always_comb begin
    if (cfg_i.frame_width == 7'd0) begin
      w = EW'(1);
    end else if ({25'd0, cfg_i.frame_width} > 32'(MAX_WIDTH)) begin
      w = EW'(MAX_WIDTH);
    end else begin
      w = EW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == 7'd0) begin
      h = EW'(1);
    end else if ({25'd0, cfg_i.frame_height} > 32'(MAX_HEIGHT)) begin
      h = EW'(MAX_HEIGHT);
    end else begin
      h = EW'(cfg_i.frame_height);
    end
  end

  assign out_w = cfg_i.transform_mode ? h : w;
  assign out_h = cfg_i.transform_mode ? w : h;

  assign last_read = (EW'(rd_row_q) == out_h - EW'(1)) && (EW'(rd_col_q) == out_w - EW'(1));

  always_comb begin
    if (cfg_i.transform_mode) begin
      src_row = DW'(h - EW'(1) - EW'(rd_col_q));
      src_col = rd_row_q;
    end else begin
      src_row = rd_row_q;
      src_col = DW'(w - EW'(1) - EW'(rd_col_q));
    end
  end

  assign rd_addr_o = (bank_q ? AW'(0) : AW'(BANK))
                   + AW'(src_row) * AW'(MAX_WIDTH) + AW'(src_col);
  assign wr_addr_o = (bank_q ? AW'(BANK) : AW'(0))
                   + AW'(wr_row_q) * AW'(MAX_WIDTH) + AW'(wr_col_q);

  assign meta_o = '{seen: seen_q, eof: seen_q && last_read};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_row_q <= '0;
      wr_col_q <= '0;
      rd_row_q <= '0;
      rd_col_q <= '0;
      bank_q   <= 1'b0;
      seen_q   <= 1'b0;
    end else if (cfg_i.restart) begin
      wr_row_q <= '0;
      wr_col_q <= '0;
      rd_row_q <= '0;
      rd_col_q <= '0;
    end else if (step_i) begin
      if (EW'(rd_col_q) + EW'(1) >= out_w) begin
        rd_col_q <= '0;
        rd_row_q <= (EW'(rd_row_q) + EW'(1) >= out_h) ? '0 : rd_row_q + DW'(1);
      end else begin
        rd_col_q <= rd_col_q + DW'(1);
      end
      if (EW'(wr_col_q) + EW'(1) >= w) begin
        wr_col_q <= '0;
        if (EW'(wr_row_q) + EW'(1) >= h) begin
          wr_row_q <= '0;
          bank_q   <= ~bank_q;
          seen_q   <= 1'b1;
        end else begin
          wr_row_q <= wr_row_q + DW'(1);
        end
      end else begin
        wr_col_q <= wr_col_q + DW'(1);
      end
    end
  end

endmodule

FILE: rtl/ffre_frame_mem.sv
// ----------------------------------------------------------------------------
// ffre_frame_mem
// Two-bank frame store, one write and one registered read per cycle.
// Zeroed by a sweep after reset.
// ----------------------------------------------------------------------------
module ffre_frame_mem import ffre_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int DEPTH     = 2 * MAX_WIDTH * MAX_HEIGHT,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  output logic          busy_o
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] clr_addr_q;
  logic          clr_busy_q;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;

  assign we = clr_busy_q || wr_en_i;
  assign wa = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wd = clr_busy_q ? 8'd0 : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

FILE: rtl/ffre_out_buf.sv
// ----------------------------------------------------------------------------
// ffre_out_buf
// Read-stage tracking and two-entry result queue decoupling the output.
// ----------------------------------------------------------------------------
module ffre_out_buf import ffre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               issue_i,
  input  rd_meta_t           meta_i,
  input  logic [7:0]         rd_data_i,
  output logic               can_take_o,
  ffre_stream_if.source      out_chan
);

  logic     s1_valid_q;
  rd_meta_t s1_meta_q;
  pix_out_t entry;
  pix_out_t buf_q [2];
  logic     wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, occ;
  logic     push, pop;

  assign entry = '{pixel_out:    s1_meta_q.seen ? rd_data_i : 8'd0,
                   out_valid:    s1_meta_q.seen,
                   end_of_frame: s1_meta_q.eof};

  assign push = s1_valid_q;
  assign pop  = (cnt_q != 2'd0) && out_chan.ready;
  assign occ  = {1'b0, s1_valid_q} + cnt_q;
  assign can_take_o = (occ - {1'b0, pop}) <= 2'd1;

  assign out_chan.valid = cnt_q != 2'd0;
  assign out_chan.data  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      s1_valid_q <= issue_i;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_meta_q <= meta_i;
    end
    if (push) begin
      buf_q[wr_ptr_q] <= entry;
    end
  end

endmodule
